### rtl/trlp_pkg.sv
// trlp_pkg: shared types and constants of the reply line parser
`timescale 1ns / 1ps
`default_nettype none
package trlp_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned NUM_W   = 16;

  // character classes seen by the phase machine
  typedef enum logic [4:0] {
    SYM_END,
    SYM_ZERO,
    SYM_DIGIT,
    SYM_LC_I,
    SYM_LC_D,
    SYM_LC_X,
    SYM_COLON,
    SYM_UC_R,
    SYM_UC_C,
    SYM_UC_V,
    SYM_COMMA,
    SYM_MINUS,
    SYM_UC_E,
    SYM_UC_I,
    SYM_UC_D,
    SYM_UC_X,
    SYM_UC_O,
    SYM_UC_K,
    SYM_OTHER
  } sym_t;

  typedef struct packed {
    sym_t               sym;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  typedef enum logic [4:0] {
    PH_START,
    PH_I_D,
    PH_I_X,
    PH_I_COLON,
    PH_IDX_FIRST,
    PH_IDX_DIGITS,
    PH_VAL_FIRST,
    PH_VAL_DIGITS,
    PH_R_C,
    PH_R_V,
    PH_R_COMMA,
    PH_NUM_SIGN,
    PH_NUM_DIGITS,
    PH_E_R1,
    PH_E_R2,
    PH_E_COMMA,
    PH_E_I,
    PH_E_D,
    PH_E_X,
    PH_E_COMMA2,
    PH_O_K,
    PH_ACCEPT,
    PH_REJECT
  } phase_t;

  localparam logic [2:0] FORM_NONE = 3'd0;
  localparam logic [2:0] FORM_IDX  = 3'd1;
  localparam logic [2:0] FORM_RCV  = 3'd2;
  localparam logic [2:0] FORM_ERR  = 3'd3;
  localparam logic [2:0] FORM_OK   = 3'd4;

endpackage
`default_nettype wire

### rtl/trlp_if.sv
// trlp_if: input and result channel interfaces of the reply line parser
`timescale 1ns / 1ps
`default_nettype none
interface trlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;
  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface trlp_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [2:0]         msg_type;
  logic [15:0]        index;
  logic signed [15:0] level;
  modport source (output valid, output accepted, output msg_type, output index,
                  output level, input ready);
  modport sink (input valid, input accepted, input msg_type, input index,
                input level, output ready);
endinterface
`default_nettype wire

### rtl/trlp_front.sv
// trlp_front: accepts input items and classifies each character
`timescale 1ns / 1ps
`default_nettype none
module trlp_front (
  trlp_in_if.sink          in_chan,
  output logic             tok_valid,
  input  logic             tok_ready,
  output trlp_pkg::token_t tok
);

  assign tok_valid     = in_chan.valid;
  assign in_chan.ready = tok_ready;

  always_comb begin
    tok.digit = in_chan.ch[trlp_pkg::DIGIT_W-1:0];
    if (in_chan.line_end) begin
      tok.sym = trlp_pkg::SYM_END;
    end else if (in_chan.ch >= 8'h30 && in_chan.ch <= 8'h39) begin
      tok.sym = trlp_pkg::SYM_DIGIT;
    end else begin
      unique case (in_chan.ch)
        8'h00:   tok.sym = trlp_pkg::SYM_ZERO;
        8'h69:   tok.sym = trlp_pkg::SYM_LC_I;
        8'h64:   tok.sym = trlp_pkg::SYM_LC_D;
        8'h78:   tok.sym = trlp_pkg::SYM_LC_X;
        8'h3a:   tok.sym = trlp_pkg::SYM_COLON;
        8'h52:   tok.sym = trlp_pkg::SYM_UC_R;
        8'h43:   tok.sym = trlp_pkg::SYM_UC_C;
        8'h56:   tok.sym = trlp_pkg::SYM_UC_V;
        8'h2c:   tok.sym = trlp_pkg::SYM_COMMA;
        8'h2d:   tok.sym = trlp_pkg::SYM_MINUS;
        8'h45:   tok.sym = trlp_pkg::SYM_UC_E;
        8'h49:   tok.sym = trlp_pkg::SYM_UC_I;
        8'h44:   tok.sym = trlp_pkg::SYM_UC_D;
        8'h58:   tok.sym = trlp_pkg::SYM_UC_X;
        8'h4f:   tok.sym = trlp_pkg::SYM_UC_O;
        8'h4b:   tok.sym = trlp_pkg::SYM_UC_K;
        default: tok.sym = trlp_pkg::SYM_OTHER;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/trlp_queue.sv
// trlp_queue: short token queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module trlp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  trlp_pkg::token_t wr_token,
  output logic             rd_valid,
  input  logic             rd_ready,
  output trlp_pkg::token_t rd_token
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  trlp_pkg::token_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_token = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_token;
    end
  end

endmodule
`default_nettype wire

### rtl/trlp_back.sv
// trlp_back: phase machine, number accumulators and result register
`timescale 1ns / 1ps
`default_nettype none
module trlp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  trlp_pkg::token_t tok,
  trlp_out_if.source       out_chan
);

  localparam int unsigned NW = trlp_pkg::NUM_W;

  trlp_pkg::phase_t phase_r, phase_nxt;
  logic [NW-1:0]    index_acc_r, index_acc_nxt;
  logic [NW-1:0]    value_acc_r, value_acc_nxt;
  logic             negative_r, negative_nxt;
  logic [2:0]       form_r, form_nxt;

  logic             out_valid_r;
  logic             accepted_r;
  logic [2:0]       msg_type_r;
  logic [NW-1:0]    index_r;
  logic [NW-1:0]    level_r;

  logic             take, take_end;
  logic             ends_ok;
  logic             res_accepted;
  logic [2:0]       res_type;
  logic [NW-1:0]    res_index, res_level;
  logic [NW-1:0]    index_step, value_step;
  logic [NW-1:0]    index_neg, value_neg;

  function automatic logic ends_accepted(trlp_pkg::phase_t ph);
    logic r;
    unique case (ph)
      trlp_pkg::PH_VAL_DIGITS, trlp_pkg::PH_NUM_SIGN, trlp_pkg::PH_NUM_DIGITS,
      trlp_pkg::PH_E_COMMA, trlp_pkg::PH_E_I, trlp_pkg::PH_E_D, trlp_pkg::PH_E_X,
      trlp_pkg::PH_E_COMMA2, trlp_pkg::PH_ACCEPT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  assign tok_ready = (tok.sym != trlp_pkg::SYM_END) || !out_valid_r || out_chan.ready;
  assign take      = tok_valid && tok_ready;
  assign take_end  = take && (tok.sym == trlp_pkg::SYM_END);

  // acc * 10 + digit, wrapping
  assign index_step = (index_acc_r << 3) + (index_acc_r << 1)
                    + {{(NW-trlp_pkg::DIGIT_W){1'b0}}, tok.digit};
  assign value_step = (value_acc_r << 3) + (value_acc_r << 1)
                    + {{(NW-trlp_pkg::DIGIT_W){1'b0}}, tok.digit};
  assign index_neg  = ~index_acc_r + 1'b1;
  assign value_neg  = ~value_acc_r + 1'b1;
  assign ends_ok    = ends_accepted(phase_r);

  // result of the line so far
  always_comb begin
    res_accepted = ends_ok;
    res_type     = trlp_pkg::FORM_NONE;
    res_index    = '0;
    res_level    = '0;
    if (ends_ok) begin
      res_type = form_r;
      if (form_r == trlp_pkg::FORM_IDX) begin
        res_index = index_acc_r;
        res_level = negative_r ? value_neg : value_acc_r;
      end else if (form_r == trlp_pkg::FORM_RCV || form_r == trlp_pkg::FORM_ERR) begin
        res_index = negative_r ? index_neg : index_acc_r;
      end
    end else if (form_r == trlp_pkg::FORM_IDX) begin
      res_index = index_acc_r;
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    index_acc_nxt = index_acc_r;
    value_acc_nxt = value_acc_r;
    negative_nxt  = negative_r;
    form_nxt      = form_r;
    if (take_end) begin
      phase_nxt     = trlp_pkg::PH_START;
      index_acc_nxt = '0;
      value_acc_nxt = '0;
      negative_nxt  = 1'b0;
      form_nxt      = trlp_pkg::FORM_NONE;
    end else if (take && phase_r != trlp_pkg::PH_ACCEPT && phase_r != trlp_pkg::PH_REJECT) begin
      if (tok.sym == trlp_pkg::SYM_ZERO) begin
        phase_nxt = ends_ok ? trlp_pkg::PH_ACCEPT : trlp_pkg::PH_REJECT;
      end else begin
        unique case (phase_r)
          trlp_pkg::PH_START: begin
            phase_nxt = trlp_pkg::PH_REJECT;
            if (tok.sym == trlp_pkg::SYM_LC_I) begin
              form_nxt  = trlp_pkg::FORM_IDX;
              phase_nxt = trlp_pkg::PH_I_D;
            end else if (tok.sym == trlp_pkg::SYM_UC_R) begin
              form_nxt  = trlp_pkg::FORM_RCV;
              phase_nxt = trlp_pkg::PH_R_C;
            end else if (tok.sym == trlp_pkg::SYM_UC_E) begin
              form_nxt  = trlp_pkg::FORM_ERR;
              phase_nxt = trlp_pkg::PH_E_R1;
            end else if (tok.sym == trlp_pkg::SYM_UC_O) begin
              form_nxt  = trlp_pkg::FORM_OK;
              phase_nxt = trlp_pkg::PH_O_K;
            end
          end
          trlp_pkg::PH_I_D: phase_nxt = (tok.sym == trlp_pkg::SYM_LC_D) ?
                                        trlp_pkg::PH_I_X : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_I_X: phase_nxt = (tok.sym == trlp_pkg::SYM_LC_X) ?
                                        trlp_pkg::PH_I_COLON : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_I_COLON: phase_nxt = (tok.sym == trlp_pkg::SYM_COLON) ?
                                            trlp_pkg::PH_IDX_FIRST : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_IDX_FIRST: begin
            if (tok.sym == trlp_pkg::SYM_DIGIT) begin
              index_acc_nxt = index_step;
              phase_nxt     = trlp_pkg::PH_IDX_DIGITS;
            end else begin
              phase_nxt = trlp_pkg::PH_REJECT;
            end
          end
          trlp_pkg::PH_IDX_DIGITS: begin
            if (tok.sym == trlp_pkg::SYM_DIGIT) begin
              index_acc_nxt = index_step;
            end else begin
              phase_nxt = (tok.sym == trlp_pkg::SYM_COLON) ?
                          trlp_pkg::PH_VAL_FIRST : trlp_pkg::PH_REJECT;
            end
          end
          trlp_pkg::PH_VAL_FIRST: begin
            if (tok.sym == trlp_pkg::SYM_MINUS) begin
              negative_nxt = 1'b1;
              phase_nxt    = trlp_pkg::PH_VAL_DIGITS;
            end else if (tok.sym == trlp_pkg::SYM_DIGIT) begin
              value_acc_nxt = value_step;
              phase_nxt     = trlp_pkg::PH_VAL_DIGITS;
            end else begin
              phase_nxt = trlp_pkg::PH_REJECT;
            end
          end
          trlp_pkg::PH_VAL_DIGITS: begin
            if (tok.sym == trlp_pkg::SYM_DIGIT) begin
              value_acc_nxt = value_step;
            end else begin
              phase_nxt = trlp_pkg::PH_ACCEPT;
            end
          end
          trlp_pkg::PH_R_C: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_C) ?
                                        trlp_pkg::PH_R_V : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_R_V: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_V) ?
                                        trlp_pkg::PH_R_COMMA : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_R_COMMA: phase_nxt = (tok.sym == trlp_pkg::SYM_COMMA) ?
                                            trlp_pkg::PH_NUM_SIGN : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_NUM_SIGN: begin
            if (tok.sym == trlp_pkg::SYM_MINUS) begin
              negative_nxt = 1'b1;
              phase_nxt    = trlp_pkg::PH_NUM_DIGITS;
            end else if (tok.sym == trlp_pkg::SYM_DIGIT) begin
              index_acc_nxt = index_step;
              phase_nxt     = trlp_pkg::PH_NUM_DIGITS;
            end else begin
              phase_nxt = trlp_pkg::PH_ACCEPT;
            end
          end
          trlp_pkg::PH_NUM_DIGITS: begin
            if (tok.sym == trlp_pkg::SYM_DIGIT) begin
              index_acc_nxt = index_step;
            end else begin
              phase_nxt = trlp_pkg::PH_ACCEPT;
            end
          end
          trlp_pkg::PH_E_R1: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_R) ?
                                         trlp_pkg::PH_E_R2 : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_E_R2: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_R) ?
                                         trlp_pkg::PH_E_COMMA : trlp_pkg::PH_REJECT;
          trlp_pkg::PH_E_COMMA: phase_nxt = (tok.sym == trlp_pkg::SYM_COMMA) ?
                                            trlp_pkg::PH_E_I : trlp_pkg::PH_ACCEPT;
          trlp_pkg::PH_E_I: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_I) ?
                                        trlp_pkg::PH_E_D : trlp_pkg::PH_ACCEPT;
          trlp_pkg::PH_E_D: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_D) ?
                                        trlp_pkg::PH_E_X : trlp_pkg::PH_ACCEPT;
          trlp_pkg::PH_E_X: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_X) ?
                                        trlp_pkg::PH_E_COMMA2 : trlp_pkg::PH_ACCEPT;
          trlp_pkg::PH_E_COMMA2: phase_nxt = (tok.sym == trlp_pkg::SYM_COMMA) ?
                                             trlp_pkg::PH_NUM_SIGN : trlp_pkg::PH_ACCEPT;
          trlp_pkg::PH_O_K: phase_nxt = (tok.sym == trlp_pkg::SYM_UC_K) ?
                                        trlp_pkg::PH_ACCEPT : trlp_pkg::PH_REJECT;
          default: phase_nxt = trlp_pkg::PH_REJECT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= trlp_pkg::PH_START;
      index_acc_r <= '0;
      value_acc_r <= '0;
      negative_r  <= 1'b0;
      form_r      <= trlp_pkg::FORM_NONE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      index_acc_r <= index_acc_nxt;
      value_acc_r <= value_acc_nxt;
      negative_r  <= negative_nxt;
      form_r      <= form_nxt;
      if (take_end) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      accepted_r <= res_accepted;
      msg_type_r <= res_type;
      index_r    <= res_index;
      level_r    <= res_level;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.accepted = accepted_r;
  assign out_chan.msg_type = msg_type_r;
  assign out_chan.index    = index_r;
  assign out_chan.level    = level_r;

endmodule
`default_nettype wire

### rtl/text_reply_line_parser_core.sv
// text_reply_line_parser_core: top level of the reply line parser
`timescale 1ns / 1ps
`default_nettype none
// Takes a reply line one character item at a time and closes it with a line_end
// item, which yields one result (accepted, msg_type, index, level); character
// items yield nothing. One item is accepted every cycle while the queue has
// room: the front classifies the character and pushes it into a queue of
// QUEUE_DEPTH entries, and the back pops one token a cycle into the phase
// machine and its 16-bit accumulators, holding a line_end token while the last
// result waits. The back registers each result in the output register, where it
// may wait while further characters keep flowing into the queue.
module text_reply_line_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  trlp_in_if.sink     in_chan,
  trlp_out_if.source  out_chan
);

  logic             f_valid, f_ready;
  trlp_pkg::token_t f_tok;
  logic             b_valid, b_ready;
  trlp_pkg::token_t b_tok;

  trlp_front u_front (
    .in_chan   (in_chan),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  trlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_token (f_tok),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_token (b_tok)
  );

  trlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

### rtl/trlp_checker.sv
// trlp_checker: port-level assertions of the reply line parser, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module trlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [2:0]  out_msg_type,
  input logic [15:0] out_index,
  input logic [15:0] out_level
);

  // a pending result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // rejected line has no type and no level
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_msg_type == trlp_pkg::FORM_NONE && out_level == '0)
    else $error("rejected line with type or level");

  // accepted line carries a known type
  a_accept_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_msg_type == trlp_pkg::FORM_IDX
      || out_msg_type == trlp_pkg::FORM_RCV || out_msg_type == trlp_pkg::FORM_ERR
      || out_msg_type == trlp_pkg::FORM_OK)
    else $error("accepted line with bad type");

  // only idx lines carry a level, ok lines carry nothing
  a_level_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_type != trlp_pkg::FORM_IDX |-> out_level == '0
      && (out_msg_type != trlp_pkg::FORM_OK || out_index == '0))
    else $error("level or index on wrong form");

endmodule

bind text_reply_line_parser_core trlp_checker u_trlp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_accepted (out_chan.accepted),
  .out_msg_type (out_chan.msg_type),
  .out_index    (out_chan.index),
  .out_level    (out_chan.level)
);
`default_nettype wire

### bench/text_reply_line_parser_core_test.sv
// text_reply_line_parser_core_test: self-checking bench of the reply line parser core
`timescale 1ns / 1ps
module text_reply_line_parser_core_test;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         msg_type;
    logic [15:0]        index;
    logic signed [15:0] level;
  } reply_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  trlp_in_if  in_chan();
  trlp_out_if out_chan();

  text_reply_line_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  item_t  pending_items[$];
  reply_t expected_replies[$];
  int     mismatches = 0;
  int     item_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  logic   hold_req = 1'b0;
  logic   holding;
  logic   hold_done;
  int     hold_cnt;

  // line parser copy
  trlp_pkg::phase_t lp_phase = trlp_pkg::PH_START;
  logic [15:0]      lp_index = '0;
  logic [15:0]      lp_value = '0;
  logic             lp_neg = 1'b0;
  logic [2:0]       lp_form = trlp_pkg::FORM_NONE;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.ch = '0;
    in_chan.line_end = 1'b0;
    out_chan.ready = 1'b0;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
    return acc * 16'd10 + {12'd0, c[3:0]};
  endfunction

  function automatic logic line_complete(input trlp_pkg::phase_t p);
    case (p)
      trlp_pkg::PH_VAL_DIGITS, trlp_pkg::PH_NUM_SIGN, trlp_pkg::PH_NUM_DIGITS,
      trlp_pkg::PH_E_COMMA, trlp_pkg::PH_E_I, trlp_pkg::PH_E_D, trlp_pkg::PH_E_X,
      trlp_pkg::PH_E_COMMA2, trlp_pkg::PH_ACCEPT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic trlp_pkg::phase_t want_char(input logic [7:0] c,
                                                 input logic [7:0] want,
                                                 input trlp_pkg::phase_t hit,
                                                 input trlp_pkg::phase_t miss);
    return (c == want) ? hit : miss;
  endfunction

  task automatic parse_char(input logic [7:0] c);
    case (lp_phase)
      trlp_pkg::PH_START: begin
        if (c == "i") begin
          lp_form = trlp_pkg::FORM_IDX; lp_phase = trlp_pkg::PH_I_D;
        end else if (c == "R") begin
          lp_form = trlp_pkg::FORM_RCV; lp_phase = trlp_pkg::PH_R_C;
        end else if (c == "E") begin
          lp_form = trlp_pkg::FORM_ERR; lp_phase = trlp_pkg::PH_E_R1;
        end else if (c == "O") begin
          lp_form = trlp_pkg::FORM_OK; lp_phase = trlp_pkg::PH_O_K;
        end else begin
          lp_phase = trlp_pkg::PH_REJECT;
        end
      end
      trlp_pkg::PH_I_D:
        lp_phase = want_char(c, "d", trlp_pkg::PH_I_X, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_I_X:
        lp_phase = want_char(c, "x", trlp_pkg::PH_I_COLON, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_I_COLON:
        lp_phase = want_char(c, ":", trlp_pkg::PH_IDX_FIRST, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_IDX_FIRST: begin
        if (is_digit(c)) begin
          lp_index = add_digit(lp_index, c); lp_phase = trlp_pkg::PH_IDX_DIGITS;
        end else begin
          lp_phase = trlp_pkg::PH_REJECT;
        end
      end
      trlp_pkg::PH_IDX_DIGITS: begin
        if (is_digit(c)) lp_index = add_digit(lp_index, c);
        else lp_phase = (c == ":") ? trlp_pkg::PH_VAL_FIRST : trlp_pkg::PH_REJECT;
      end
      trlp_pkg::PH_VAL_FIRST: begin
        if (c == "-") begin
          lp_neg = 1'b1; lp_phase = trlp_pkg::PH_VAL_DIGITS;
        end else if (is_digit(c)) begin
          lp_value = add_digit(lp_value, c); lp_phase = trlp_pkg::PH_VAL_DIGITS;
        end else begin
          lp_phase = trlp_pkg::PH_REJECT;
        end
      end
      trlp_pkg::PH_VAL_DIGITS: begin
        if (is_digit(c)) lp_value = add_digit(lp_value, c);
        else lp_phase = trlp_pkg::PH_ACCEPT;
      end
      trlp_pkg::PH_R_C:
        lp_phase = want_char(c, "C", trlp_pkg::PH_R_V, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_R_V:
        lp_phase = want_char(c, "V", trlp_pkg::PH_R_COMMA, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_R_COMMA:
        lp_phase = want_char(c, ",", trlp_pkg::PH_NUM_SIGN, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_NUM_SIGN: begin
        if (c == "-") begin
          lp_neg = 1'b1; lp_phase = trlp_pkg::PH_NUM_DIGITS;
        end else if (is_digit(c)) begin
          lp_index = add_digit(lp_index, c); lp_phase = trlp_pkg::PH_NUM_DIGITS;
        end else begin
          lp_phase = trlp_pkg::PH_ACCEPT;
        end
      end
      trlp_pkg::PH_NUM_DIGITS: begin
        if (is_digit(c)) lp_index = add_digit(lp_index, c);
        else lp_phase = trlp_pkg::PH_ACCEPT;
      end
      trlp_pkg::PH_E_R1:
        lp_phase = want_char(c, "R", trlp_pkg::PH_E_R2, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_E_R2:
        lp_phase = want_char(c, "R", trlp_pkg::PH_E_COMMA, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_E_COMMA:
        lp_phase = want_char(c, ",", trlp_pkg::PH_E_I, trlp_pkg::PH_ACCEPT);
      trlp_pkg::PH_E_I:
        lp_phase = want_char(c, "I", trlp_pkg::PH_E_D, trlp_pkg::PH_ACCEPT);
      trlp_pkg::PH_E_D:
        lp_phase = want_char(c, "D", trlp_pkg::PH_E_X, trlp_pkg::PH_ACCEPT);
      trlp_pkg::PH_E_X:
        lp_phase = want_char(c, "X", trlp_pkg::PH_E_COMMA2, trlp_pkg::PH_ACCEPT);
      trlp_pkg::PH_E_COMMA2:
        lp_phase = want_char(c, ",", trlp_pkg::PH_NUM_SIGN, trlp_pkg::PH_ACCEPT);
      trlp_pkg::PH_O_K:
        lp_phase = want_char(c, "K", trlp_pkg::PH_ACCEPT, trlp_pkg::PH_REJECT);
      trlp_pkg::PH_ACCEPT: lp_phase = trlp_pkg::PH_ACCEPT;
      default:             lp_phase = trlp_pkg::PH_REJECT;
    endcase
  endtask

  task automatic parse_item(input item_t it, output logic got, output reply_t r);
    r = '0;
    got = it.line_end;
    if (!it.line_end) begin
      if (lp_phase != trlp_pkg::PH_ACCEPT && lp_phase != trlp_pkg::PH_REJECT) begin
        if (it.ch == 8'h00) begin
          lp_phase = line_complete(lp_phase) ? trlp_pkg::PH_ACCEPT : trlp_pkg::PH_REJECT;
        end else begin
          parse_char(it.ch);
        end
      end
    end else begin
      if (line_complete(lp_phase)) begin
        r.accepted = 1'b1;
        r.msg_type = lp_form;
        if (lp_form == trlp_pkg::FORM_IDX) begin
          r.index = lp_index;
          r.level = lp_neg ? 16'd0 - lp_value : lp_value;
        end else if (lp_form == trlp_pkg::FORM_RCV || lp_form == trlp_pkg::FORM_ERR) begin
          r.index = lp_neg ? 16'd0 - lp_index : lp_index;
        end
      end else if (lp_form == trlp_pkg::FORM_IDX) begin
        r.index = lp_index;
      end
      lp_phase = trlp_pkg::PH_START;
      lp_index = '0;
      lp_value = '0;
      lp_neg = 1'b0;
      lp_form = trlp_pkg::FORM_NONE;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic   hold;
    item_t  head;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      hold = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        void'(pending_items.pop_front());
        hold = 1'b0;
      end
      if (!hold) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          head = pending_items[0];
          in_chan.ch <= head.ch;
          in_chan.line_end <= head.line_end;
          in_chan.valid <= 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      holding <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req && !hold_done) begin
      holding <= 1'b1;
      hold_done <= 1'b1;
      hold_cnt <= 400;
    end else if (holding) begin
      if (hold_cnt == 1) holding <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    logic   got;
    reply_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        parse_item('{ch: in_chan.ch, line_end: in_chan.line_end}, got, want);
        if (got) expected_replies.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", {out_chan.accepted, out_chan.msg_type},
                          32'd0);
        end else begin
          want = expected_replies.pop_front();
          if (out_chan.accepted !== want.accepted)
            report_mismatch("accepted", out_chan.accepted, want.accepted);
          if (out_chan.msg_type !== want.msg_type)
            report_mismatch("msg_type", out_chan.msg_type, want.msg_type);
          if (out_chan.index !== want.index)
            report_mismatch("index", out_chan.index, want.index);
          if (out_chan.level !== want.level)
            report_mismatch("level", out_chan.level, want.level);
        end
      end
    end
  end

  function automatic void add_text(ref byte_q_t s, input string t);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endfunction

  function automatic void add_noise(ref byte_q_t s, input int n);
    for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(255)));
  endfunction

  function automatic int digit_count();
    return ($urandom_range(3) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
  endfunction

  function automatic void add_digits(ref byte_q_t s, input int n);
    for (int i = 0; i < n; i++) s.push_back(8'h30 + 8'($urandom_range(9)));
  endfunction

  task automatic send_line(input byte_q_t s);
    foreach (s[i]) pending_items.push_back('{ch: s[i], line_end: 1'b0});
    pending_items.push_back('{ch: 8'($urandom_range(255)), line_end: 1'b1});
    item_count += s.size() + 1;
  endtask

  task automatic send_text(input string t);
    byte_q_t s;
    s = {};
    add_text(s, t);
    send_line(s);
  endtask

  task automatic form_line(output byte_q_t s);
    string err_tail;
    int    n;
    err_tail = ",IDX,";
    s = {};
    case ($urandom_range(4))
      0: begin
        add_text(s, "idx:");
        add_digits(s, 1 + digit_count());
        add_text(s, ":");
        if ($urandom_range(2) == 0) add_text(s, "-");
        add_digits(s, digit_count());
      end
      1: begin
        add_text(s, "RCV,");
        if ($urandom_range(2) == 0) add_text(s, "-");
        add_digits(s, digit_count());
      end
      2: begin
        add_text(s, "ERR,IDX,");
        if ($urandom_range(2) == 0) add_text(s, "-");
        add_digits(s, digit_count());
      end
      3: begin
        add_text(s, "ERR");
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) s.push_back(err_tail[i]);
      end
      default: add_text(s, "OK");
    endcase
    if ($urandom_range(1) == 1) add_noise(s, $urandom_range(1, 3));
  endtask

  task automatic random_line(output byte_q_t s);
    string starts;
    int    sel;
    int    pos;
    starts = "iREO";
    sel = $urandom_range(99);
    if (sel < 70) begin
      form_line(s);
    end else if (sel < 80) begin
      s = {};
      if ($urandom_range(1) == 1) s.push_back(starts[$urandom_range(3)]);
      add_noise(s, $urandom_range(8));
    end else begin
      form_line(s);
      pos = $urandom_range(s.size() - 1);
      case ($urandom_range(2))
        0: s[pos] = 8'($urandom_range(255));
        1: while (s.size() > pos) void'(s.pop_back());
        default: s.insert(pos, 8'h00);
      endcase
    end
  endtask

  task automatic send_random(input int target);
    byte_q_t s;
    int      start;
    start = item_count;
    while (item_count - start < target) begin
      random_line(s);
      send_line(s);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_chan.valid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic send_directed();
    byte_q_t s;
    send_text("");
    send_text("OK");
    send_text("OKjunk");
    send_text("idx:0:0");
    send_text("idx:65535:32767");
    send_text("idx:65535:-32768");
    send_text("idx:99999:-99999");
    send_text("idx:7:-");
    send_text("idx:1:2x9");
    send_text("idx:42");
    send_text("idx:");
    send_text("idx:4x");
    send_text("RCV,");
    send_text("RCV,-");
    send_text("RCV,-1");
    send_text("RCV,65536");
    send_text("ERR,IDX,12");
    send_text("ERR,IDX,-");
    send_text("ERR");
    send_text("ERR,ID");
    send_text("EXR");
    send_text("Q");
    s = {};
    add_text(s, "idx:3");
    s.push_back(8'h00);
    add_text(s, ":5");
    send_line(s);
    s = {};
    add_text(s, "RCV,1");
    s.push_back(8'h00);
    add_text(s, "2");
    send_line(s);
    s = {8'h00, "O", "K"};
    send_line(s);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no idling, with one long receiver hold-off while items keep coming
    idle_pct = 0;
    stall_pct = 0;
    send_directed();
    hold_req = 1'b1;
    send_random(240);
    wait_idle();

    // each later phase starts only once every reply has come back
    idle_pct = 63;
    stall_pct = 0;
    send_random(240);
    wait_idle();

    idle_pct = 0;
    stall_pct = 63;
    send_random(240);
    wait_idle();

    idle_pct = 33;
    stall_pct = 33;
    send_random(240);
    wait_idle();

    repeat (16) @(negedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("text_reply_line_parser_core: match");
    end else begin
      $display("text_reply_line_parser_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("text_reply_line_parser_core: mismatch");
    $finish;
  end

endmodule
